// File: hw/rtl/lht_pkg.sv
// Shared constants and types for the label hash table.
`timescale 1ns / 1ps
`default_nettype none

package lht_pkg;

	// table geometry
	localparam int CAPACITY  = 4096;
	localparam int IDX_W     = $clog2(CAPACITY);
	localparam int NF_W      = $clog2(CAPACITY + 1);
	localparam int NBUCKETS  = 1024;
	localparam int BKT_W     = $clog2(NBUCKETS);
	localparam int BKT_LSB   = 16;

	// hash and range constants
	localparam logic [31:0] HASH_MUL   = 32'd65521;
	localparam logic [31:0] HASH_ADD   = 32'd31;
	localparam int          RANGE_BITS = 20;

	// field widths
	localparam int ID_W       = 31;
	localparam int OFS_W      = 32;
	localparam int SEC_W      = 8;
	localparam int EIDX_W     = 12;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;

	// action codes
	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_ABS    = 2'd1;
	localparam logic [1:0] ACT_LOOKUP = 2'd2;
	localparam logic [1:0] ACT_NONE   = 2'd3;

	// status codes
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_IGNORED = 2'd1;
	localparam logic [1:0] STAT_FULL    = 2'd2;
	localparam logic [1:0] STAT_RANGE   = 2'd3;

	// register indexes
	localparam logic REG_BSS = 1'b0;
	localparam logic REG_ABS = 1'b1;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [OFS_W-1:0] ofs;
		logic [SEC_W-1:0] sec;
		logic [IDX_W-1:0] link;
	} entry_t;

endpackage

`default_nettype wire

// File: hw/rtl/label_hash_table.sv
// Label hash table: 1024-bucket chained table, sequenced over one hash unit.
// An ignored id or a full table goes straight to the result. An insert runs the hash
// steps, the bucket head read and the head and entry write; a lookup reads the bucket head
// and then the k chain entries it visits, one read each. Input stalls until the result is
// moved to the output register, also while a stalled result blocks that register.
// Reset starts a clear of the bucket heads with input stalled; config is always taken.
`timescale 1ns / 1ps
`default_nettype none

module label_hash_table
	import lht_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	// input channel
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         action,
	input  wire logic [ID_W-1:0]    label_id,
	input  wire logic [OFS_W-1:0]   offset,
	input  wire logic [SEC_W-1:0]   section,
	// result channel
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [EIDX_W-1:0]       entry_index,
	output logic                    found,
	output logic [OFS_W-1:0]        found_offset,
	output logic [SEC_W-1:0]        found_section,
	output logic [1:0]              status,
	// configuration port
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0]      prdata,
	output logic                    pready
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_HASH1 = 3'd2;
	localparam logic [2:0] ST_HASH2 = 3'd3;
	localparam logic [2:0] ST_HEAD  = 3'd4;
	localparam logic [2:0] ST_HEADW = 3'd5;
	localparam logic [2:0] ST_CMP   = 3'd6;
	localparam logic [2:0] ST_DONE  = 3'd7;

	logic [2:0]        state_q;
	logic [BKT_W-1:0]  clr_q;
	logic [NF_W-1:0]   next_free_q;
	logic [SEC_W-1:0]  bss_q;
	logic [SEC_W-1:0]  abs_q;

	// latched item
	logic [1:0]        act_q;
	logic [ID_W-1:0]   id_q;
	logic [OFS_W-1:0]  ofs_q;
	logic [SEC_W-1:0]  sec_q;
	logic [IDX_W-1:0]  cur_q;

	// staged result
	logic [IDX_W-1:0]  r_idx_q;
	logic              r_hit_q;
	logic [OFS_W-1:0]  r_ofs_q;
	logic [SEC_W-1:0]  r_sec_q;
	logic [1:0]        r_stat_q;

	// output register
	logic              out_valid_q;
	logic [EIDX_W-1:0] o_idx_q;
	logic              o_hit_q;
	logic [OFS_W-1:0]  o_ofs_q;
	logic [SEC_W-1:0]  o_sec_q;
	logic [1:0]        o_stat_q;

	// memories
	logic [IDX_W-1:0]  bkt_mem [NBUCKETS];
	entry_t            ent_mem [CAPACITY];
	logic [IDX_W-1:0]  head_rd_q;
	entry_t            ent_rd_q;

	logic              bkt_we;
	logic [BKT_W-1:0]  bkt_addr;
	logic [IDX_W-1:0]  bkt_wdata;
	logic              ent_we;
	entry_t            ent_wdata;
	logic [IDX_W-1:0]  ent_raddr;

	logic [31:0]       hash_src;
	logic [31:0]       hash;
	logic              hash_en;
	logic [BKT_W-1:0]  bucket;
	logic              in_xfer;
	logic              out_free;
	logic              cfg_wr;
	logic [IDX_W-1:0]  new_idx;
	logic              range_warn;

	lht_hash_step u_hash (
		.clk (clk),
		.en  (hash_en),
		.src (hash_src),
		.h   (hash)
	);

	assign hash_en  = (state_q == ST_HASH1) || (state_q == ST_HASH2);
	assign hash_src = (state_q == ST_HASH1) ? {1'b0, id_q} : hash;
	assign bucket   = hash[BKT_LSB +: BKT_W];

	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign new_idx  = next_free_q[IDX_W-1:0];
	assign range_warn = (act_q == ACT_INSERT) && (ofs_q[OFS_W-1:RANGE_BITS] != '0)
		&& (sec_q != bss_q);

	// configuration registers
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_ABS) ? PDATA_W'(abs_q) : PDATA_W'(bss_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bss_q <= '0;
			abs_q <= '0;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_BSS) begin
				bss_q <= pwdata[SEC_W-1:0];
			end else begin
				abs_q <= pwdata[SEC_W-1:0];
			end
		end
	end

	// memory port control
	always_comb begin
		bkt_we    = 1'b0;
		bkt_addr  = bucket;
		bkt_wdata = new_idx;
		ent_we    = 1'b0;
		ent_wdata.id   = id_q;
		ent_wdata.ofs  = ofs_q;
		ent_wdata.sec  = (act_q == ACT_ABS) ? abs_q : sec_q;
		ent_wdata.link = head_rd_q;
		ent_raddr = ent_rd_q.link;
		case (state_q)
			ST_CLEAR: begin
				bkt_we    = 1'b1;
				bkt_addr  = clr_q;
				bkt_wdata = '0;
			end
			ST_HEADW: begin
				ent_raddr = head_rd_q;
				if (act_q != ACT_LOOKUP) begin
					bkt_we = 1'b1;
					ent_we = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (bkt_we) begin
			bkt_mem[bkt_addr] <= bkt_wdata;
		end
		head_rd_q <= bkt_mem[bkt_addr];
	end

	always_ff @(posedge clk) begin
		if (ent_we) begin
			ent_mem[new_idx] <= ent_wdata;
		end
		ent_rd_q <= ent_mem[ent_raddr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			next_free_q <= NF_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			// drop the result once taken, unless a new one is staged this cycle
			if (out_valid_q && !out_stall && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == BKT_W'(NBUCKETS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_xfer) begin
						if (label_id == '0 || action == ACT_NONE) begin
							state_q <= ST_DONE;
						end else if (action != ACT_LOOKUP
							&& next_free_q >= NF_W'(CAPACITY)) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_HASH1;
						end
					end
				end
				ST_HASH1: state_q <= ST_HASH2;
				ST_HASH2: state_q <= ST_HEAD;
				ST_HEAD:  state_q <= ST_HEADW;
				ST_HEADW: begin
					if (act_q != ACT_LOOKUP) begin
						next_free_q <= next_free_q + 1'b1;
						state_q     <= ST_DONE;
					end else if (head_rd_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (ent_rd_q.id == id_q || ent_rd_q.link == '0) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item, walk and result registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				act_q    <= action;
				id_q     <= label_id;
				ofs_q    <= offset;
				sec_q    <= section;
				r_idx_q  <= '0;
				r_hit_q  <= 1'b0;
				r_ofs_q  <= '0;
				r_sec_q  <= '0;
				if (label_id == '0 || action == ACT_NONE) begin
					r_stat_q <= STAT_IGNORED;
				end else if (action != ACT_LOOKUP && next_free_q >= NF_W'(CAPACITY)) begin
					r_stat_q <= STAT_FULL;
				end else begin
					r_stat_q <= STAT_OK;
				end
			end
			ST_HEADW: begin
				cur_q <= head_rd_q;
				if (act_q != ACT_LOOKUP) begin
					r_idx_q  <= new_idx;
					r_stat_q <= range_warn ? STAT_RANGE : STAT_OK;
				end
			end
			ST_CMP: begin
				cur_q <= ent_rd_q.link;
				if (ent_rd_q.id == id_q) begin
					r_idx_q <= cur_q;
					r_hit_q <= 1'b1;
					r_ofs_q <= ent_rd_q.ofs;
					r_sec_q <= ent_rd_q.sec;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					o_idx_q  <= EIDX_W'(r_idx_q);
					o_hit_q  <= r_hit_q;
					o_ofs_q  <= r_ofs_q;
					o_sec_q  <= r_sec_q;
					o_stat_q <= r_stat_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid     = out_valid_q;
	assign entry_index   = o_idx_q;
	assign found         = o_hit_q;
	assign found_offset  = o_ofs_q;
	assign found_section = o_sec_q;
	assign status        = o_stat_q;

endmodule

`default_nettype wire

// File: hw/rtl/lht_hash_step.sv
// Shared multiply-add unit of the hash: h = src * 65521 + 31, registered.
`timescale 1ns / 1ps
`default_nettype none

module lht_hash_step
	import lht_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [31:0] src,
	output logic      [31:0] h
);

	logic [31:0] h_q;

	always_ff @(posedge clk) begin
		if (en) begin
			h_q <= 32'(src * HASH_MUL + HASH_ADD);
		end
	end

	assign h = h_q;

endmodule

`default_nettype wire

// File: hw/rtl/lht_checker.sv
// Port-level checks for the label hash table, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module lht_checker
	import lht_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_stall,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic [EIDX_W-1:0]  entry_index,
	input wire logic               found,
	input wire logic [OFS_W-1:0]   found_offset,
	input wire logic [SEC_W-1:0]   found_section,
	input wire logic [1:0]         status
);

	// a hit is always a clean lookup at a real entry
	a_hit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> status == STAT_OK && entry_index != '0)
		else $error("hit with bad status or index");

	// offset and section are zero unless the lookup hit
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> found_offset == '0 && found_section == '0)
		else $error("data without hit");

	// ignored and full items report no entry
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STAT_IGNORED || status == STAT_FULL)
		|-> entry_index == '0 && !found)
		else $error("rejected item reports an entry");

	// bucket clear still runs right after reset
	a_clear_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> in_stall && !out_valid)
		else $error("input taken during bucket clear");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(entry_index) && $stable(status))
		else $error("stalled result changed");

endmodule

bind label_hash_table lht_checker u_lht_checker (.*);

`default_nettype wire
